### src/assert_macros.svh
// assertion macros used by the alu core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property a implies b in the same cycle
`define CHK_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("check failed");

// property a implies b in the next cycle
`define CHK_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("check failed");

`endif

### src/fxalu_pkg.sv
// package: types, command codes and constants of the fixed-point alu
`default_nettype none
package fxalu_pkg;
	localparam int WordWidth = 32;
	localparam int FracBits = 8;
	localparam int DivCells = WordWidth + FracBits;

	typedef enum logic [3:0] {
		CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
		CMD_MIN = 4'd4, CMD_MAX = 4'd5, CMD_INC = 4'd6, CMD_DEC = 4'd7,
		CMD_TOINT = 4'd8, CMD_FROMINT = 4'd9
	} cmd_t;

	typedef struct packed {
		logic [3:0] cmd;
		logic signed [WordWidth-1:0] operand_a;
		logic signed [WordWidth-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [WordWidth-1:0] result;
		logic greater;
		logic less;
		logic equal;
		logic divide_by_zero;
		logic overflow;
	} rsp_t;

	// control traveling along the cell chain
	typedef struct packed {
		logic vld;
		logic neg;
		logic dz;
	} ctl_t;
endpackage
`default_nettype wire

### src/fxalu_div_cell.sv
// one restoring divide cell: settles one quotient bit per cycle
`default_nettype none
module fxalu_div_cell #(
	parameter int W = fxalu_pkg::WordWidth,
	parameter int N = fxalu_pkg::DivCells
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire fxalu_pkg::ctl_t ctl_in,
	input  wire logic [W-1:0]   rem_in,
	input  wire logic [N-1:0]   dvd_in,
	input  wire logic [W-1:0]   dvs_in,
	output fxalu_pkg::ctl_t     ctl_out,
	output logic [W-1:0]        rem_out,
	output logic [N-1:0]        dvd_out,
	output logic [W-1:0]        dvs_out
);
	logic [W:0] trial;
	logic [W:0] diff;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_in, dvd_in[N-1]};
	assign diff = trial - {1'b0, dvs_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

	// payload: quotient bits shift into the low end of the dividend word
	always_ff @(posedge clk) begin
		rem_out <= diff[W] ? trial[W-1:0] : diff[W-1:0];
		dvd_out <= {dvd_in[N-2:0], ~diff[W]};
		dvs_out <= dvs_in;
	end
endmodule
`default_nettype wire

### src/fixed_point_alu_q24_8_core.sv
// top level: signed fixed-point alu with a chain of divide cells
//
// channel   dir  handshake      payload
// request   in   start & !busy  req (cmd, operand_a, operand_b)
// result    out  done strobe    rsp (result, flags)
//
// done rises after the transfer edge once the request has passed the input
// register, one divide cell per quotient bit and the output register; all commands ride
// alongside the divide chain; one transfer is taken every cycle, busy stays low
// reset clears the valid bits of the chain; payload registers are not reset
// the receiver cannot stall: done is a one-cycle strobe
`default_nettype none
`include "assert_macros.svh"
module fixed_point_alu_q24_8_core #(
	parameter int FRAC_BITS = fxalu_pkg::FracBits
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire fxalu_pkg::req_t req,
	output logic             done,
	output fxalu_pkg::rsp_t  rsp
);
	localparam int WORD_WIDTH = fxalu_pkg::WordWidth;
	localparam int W = WORD_WIDTH;
	localparam int N = WORD_WIDTH + FRAC_BITS;
	localparam int PW = 2 * W;
	localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

	logic xfer;
	logic [W-1:0] a, b;
	logic na, nb;
	logic [W-1:0] ma, mb;

	assign busy = 1'b0;
	assign xfer = start && !busy;
	assign a = W'(req.operand_a);
	assign b = W'(req.operand_b);
	assign na = a[W-1];
	assign nb = b[W-1];
	assign ma = na ? (~a + 1'b1) : a;
	assign mb = nb ? (~b + 1'b1) : b;

	// stage 1: simple results, flags and magnitudes
	logic vld_s1;
	logic [3:0] cmd_s1;
	logic [W-1:0] easy_s1;
	logic gt_s1, lt_s1, eq_s1, neg_s1, dz_s1;
	logic [W-1:0] ma_s1, mb_s1;
	logic [W-1:0] easy;
	logic gt;

	assign gt = $signed(a) > $signed(b);

	always_comb begin
		case (req.cmd)
			fxalu_pkg::CMD_ADD:     easy = a + b;
			fxalu_pkg::CMD_SUB:     easy = a - b;
			fxalu_pkg::CMD_MIN:     easy = gt ? b : a;
			fxalu_pkg::CMD_MAX:     easy = gt ? a : b;
			fxalu_pkg::CMD_INC:     easy = a + 1'b1;
			fxalu_pkg::CMD_DEC:     easy = a - 1'b1;
			fxalu_pkg::CMD_TOINT:   easy = W'($signed(a) >>> FRAC_BITS);
			fxalu_pkg::CMD_FROMINT: easy = a << FRAC_BITS;
			default:                easy = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= xfer;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= req.cmd;
		easy_s1 <= easy;
		gt_s1 <= gt;
		lt_s1 <= $signed(a) < $signed(b);
		eq_s1 <= a == b;
		neg_s1 <= na != nb;
		dz_s1 <= b == '0;
		ma_s1 <= ma;
		mb_s1 <= mb;
	end

	// stage 2: magnitude product, one multiplier
	logic [PW-1:0] prod_s2;
	always_ff @(posedge clk) begin
		prod_s2 <= {{W{1'b0}}, ma_s1} * {{W{1'b0}}, mb_s1};
	end

	// divide cell chain plus a side line of the other stage data
	fxalu_pkg::ctl_t ctl [0:N];
	logic [W-1:0] rem [0:N];
	logic [N-1:0] dvd [0:N];
	logic [W-1:0] dvs [0:N];

	assign ctl[0] = '{vld: vld_s1, neg: neg_s1, dz: dz_s1};
	assign rem[0] = '0;
	assign dvd[0] = {ma_s1, {FRAC_BITS{1'b0}}};
	assign dvs[0] = mb_s1;

	for (genvar i = 0; i < N; i++) begin : g_cell
		fxalu_div_cell #(.W(W), .N(N)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_in(ctl[i]), .rem_in(rem[i]), .dvd_in(dvd[i]), .dvs_in(dvs[i]),
			.ctl_out(ctl[i+1]), .rem_out(rem[i+1]), .dvd_out(dvd[i+1]),
			.dvs_out(dvs[i+1])
		);
	end

	// side line carries cmd, easy result, flags and product
	localparam int SL = 4 + W + 3 + PW;
	logic [SL-1:0] side_q [0:N-1];
	logic [SL-1:0] side_in;
	assign side_in = {cmd_s1, easy_s1, gt_s1, lt_s1, eq_s1, {PW{1'b0}}};
	always_ff @(posedge clk) begin
		side_q[0] <= side_in;
		side_q[1] <= {side_q[0][SL-1:PW], prod_s2};
		for (int j = 2; j < N; j++) side_q[j] <= side_q[j-1];
	end

	// final stage: round, saturate, select
	fxalu_pkg::ctl_t ctl_f;
	logic [SL-1:0] side_f;
	logic [3:0] cmd_f;
	logic [PW-1:0] prod_f, mrnd;
	logic [N-1:0] quo_f;
	logic [W-1:0] res_f;
	logic ovf_f, dzf_f;

	assign ctl_f = ctl[N];
	assign side_f = side_q[N-1];
	assign cmd_f = side_f[SL-1 -: 4];
	assign prod_f = side_f[PW-1:0];
	assign quo_f = dvd[N];
	assign mrnd = (prod_f + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;

	always_comb begin
		res_f = side_f[SL-5 -: W];
		ovf_f = 1'b0;
		dzf_f = 1'b0;
		case (cmd_f)
			fxalu_pkg::CMD_MUL: begin
				if (ctl_f.neg && mrnd != '0) begin
					if (mrnd > PW'(MINN)) begin
						res_f = MINN; ovf_f = 1'b1;
					end else begin
						res_f = ~mrnd[W-1:0] + 1'b1;
					end
				end else if (mrnd > PW'(MAXP)) begin
					res_f = MAXP; ovf_f = 1'b1;
				end else begin
					res_f = mrnd[W-1:0];
				end
			end
			fxalu_pkg::CMD_DIV: begin
				if (ctl_f.dz) begin
					res_f = '0; dzf_f = 1'b1;
				end else if (ctl_f.neg && quo_f != '0) begin
					if (quo_f > N'(MINN)) begin
						res_f = MINN; ovf_f = 1'b1;
					end else begin
						res_f = ~quo_f[W-1:0] + 1'b1;
					end
				end else if (quo_f > N'(MAXP)) begin
					res_f = MAXP; ovf_f = 1'b1;
				end else begin
					res_f = quo_f[W-1:0];
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_f.vld;
		end
	end

	always_ff @(posedge clk) begin
		rsp.result <= res_f;
		rsp.greater <= side_f[PW+2];
		rsp.less <= side_f[PW+1];
		rsp.equal <= side_f[PW];
		rsp.divide_by_zero <= dzf_f;
		rsp.overflow <= ovf_f;
	end

	`CHK_IMPL(a_flags_excl, clk, arst_n, done, $onehot({rsp.greater, rsp.less, rsp.equal}))
	`CHK_IMPL(a_dz_no_ovf, clk, arst_n, done, !(rsp.divide_by_zero && rsp.overflow))
	`CHK_NEXT(a_chain_out, clk, arst_n, ctl_f.vld, done)
endmodule
`default_nettype wire

### tb/sv/fixed_point_alu_q24_8_core_tb.sv
// testbench for the q24.8 fixed-point alu core: scoreboard with an integer predictor
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_alu_q24_8_core_tb;
	localparam int FRAC = fxalu_pkg::FracBits;
	localparam int WW = fxalu_pkg::WordWidth;
	localparam int LATENCY = FRAC + WW + 3;
	localparam int WATCHDOG_LIMIT = 4 * LATENCY + 2000;
	localparam logic [WW-1:0] MAX_POS = {1'b0, {(WW-1){1'b1}}};
	localparam logic [WW-1:0] MIN_NEG = {1'b1, {(WW-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	fxalu_pkg::req_t req = '0;
	logic done;
	fxalu_pkg::rsp_t rsp;
	int idle_cycles = 0;
	int fail_count = 0;

	// predicted alu result for one request
	function automatic fxalu_pkg::rsp_t alu_result(fxalu_pkg::req_t r);
		fxalu_pkg::rsp_t o;
		logic signed [WW-1:0] a, b;
		logic [63:0] ma, mb, m;
		logic na, nb, neg;
		a = r.operand_a;
		b = r.operand_b;
		o = '0;
		o.greater = a > b;
		o.less = a < b;
		o.equal = a == b;
		na = a[WW-1];
		nb = b[WW-1];
		ma = na ? 64'(-{1'b0, a}) & 64'hFFFF_FFFF : 64'(unsigned'(a));
		mb = nb ? 64'(-{1'b0, b}) & 64'hFFFF_FFFF : 64'(unsigned'(b));
		m = '0;
		case (r.cmd)
			fxalu_pkg::CMD_ADD: o.result = a + b;
			fxalu_pkg::CMD_SUB: o.result = a - b;
			fxalu_pkg::CMD_MUL, fxalu_pkg::CMD_DIV: begin
				if (r.cmd == fxalu_pkg::CMD_DIV && b == 0) begin
					o.divide_by_zero = 1'b1;
				end else begin
					if (r.cmd == fxalu_pkg::CMD_MUL)
						m = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
					else
						m = (ma << FRAC) / mb;
					neg = (na != nb) && m != 0;
					if (!neg && m > 64'(MAX_POS)) begin
						o.result = MAX_POS;
						o.overflow = 1'b1;
					end else if (neg && m > 64'(MIN_NEG)) begin
						o.result = MIN_NEG;
						o.overflow = 1'b1;
					end else begin
						o.result = neg ? -m[WW-1:0] : m[WW-1:0];
					end
				end
			end
			fxalu_pkg::CMD_MIN: o.result = (a > b) ? b : a;
			fxalu_pkg::CMD_MAX: o.result = (a > b) ? a : b;
			fxalu_pkg::CMD_INC: o.result = a + 1;
			fxalu_pkg::CMD_DEC: o.result = a - 1;
			fxalu_pkg::CMD_TOINT: o.result = a >>> FRAC;
			fxalu_pkg::CMD_FROMINT: o.result = a << FRAC;
			default: o.result = '0;
		endcase
		return o;
	endfunction

	// expected results in transfer order, checked against each done strobe
	class alu_scoreboard;
		fxalu_pkg::rsp_t pending[$];

		function void note_request(fxalu_pkg::req_t r);
			pending.push_back(alu_result(r));
		endfunction

		function void check_result(fxalu_pkg::rsp_t got);
			fxalu_pkg::rsp_t exp;
			if (pending.size() == 0) begin
				$error("unexpected result %h", got);
				fail_count++;
				return;
			end
			exp = pending.pop_front();
			if (got.result !== exp.result) begin
				$error("result: expected %h actual %h", exp.result, got.result);
				fail_count++;
			end
			if (got.greater !== exp.greater) begin
				$error("greater: expected %b actual %b", exp.greater, got.greater);
				fail_count++;
			end
			if (got.less !== exp.less) begin
				$error("less: expected %b actual %b", exp.less, got.less);
				fail_count++;
			end
			if (got.equal !== exp.equal) begin
				$error("equal: expected %b actual %b", exp.equal, got.equal);
				fail_count++;
			end
			if (got.divide_by_zero !== exp.divide_by_zero) begin
				$error("divide_by_zero: expected %b actual %b",
					exp.divide_by_zero, got.divide_by_zero);
				fail_count++;
			end
			if (got.overflow !== exp.overflow) begin
				$error("overflow: expected %b actual %b", exp.overflow, got.overflow);
				fail_count++;
			end
		endfunction
	endclass

	alu_scoreboard sb = new();

	fixed_point_alu_q24_8_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always #10 clk = ~clk;

	// note transfers, check results, count quiet cycles
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_request(req);
			if (done)
				sb.check_result(rsp);
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// watchdog on cycles without any transfer or result
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// one request transfer, with optional random idle cycles before it
	task automatic send_request(logic [3:0] cmd, logic [31:0] a, logic [31:0] b,
		bit allow_idle);
		while (allow_idle && $urandom_range(99) < 16) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= '{cmd: cmd, operand_a: a, operand_b: b};
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// random operand with a bias toward edge values and small fixed-point numbers
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(9))
			0: return MAX_POS;
			1: return MIN_NEG;
			2: return 32'($urandom_range(3)) - 32'd1;
			3: return 32'(signed'($urandom_range(2048)) - 1024) << FRAC;
			4, 5: return 32'(signed'($urandom_range(131072)) - 65536);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [3:0] c;
		logic [31:0] a, b;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every command, special cases
		send_request(fxalu_pkg::CMD_ADD, MAX_POS, 32'd1, 0);
		send_request(fxalu_pkg::CMD_SUB, MIN_NEG, 32'd1, 0);
		send_request(fxalu_pkg::CMD_MUL, MAX_POS, MAX_POS, 0);
		send_request(fxalu_pkg::CMD_MUL, MIN_NEG, MAX_POS, 0);
		send_request(fxalu_pkg::CMD_MUL, 32'h0000_0180, 32'hFFFF_FF80, 0);
		send_request(fxalu_pkg::CMD_MUL, 32'h0000_0001, 32'h0000_0080, 0);
		send_request(fxalu_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0080, 0);
		send_request(fxalu_pkg::CMD_DIV, 32'h0000_0100, 32'd0, 0);
		send_request(fxalu_pkg::CMD_DIV, MIN_NEG, 32'hFFFF_FF00, 0);
		send_request(fxalu_pkg::CMD_DIV, MIN_NEG, 32'hFFFF_FFFF, 0);
		send_request(fxalu_pkg::CMD_DIV, 32'hFFFF_FD00, 32'h0000_0200, 0);
		send_request(fxalu_pkg::CMD_DIV, 32'h0000_0001, MAX_POS, 0);
		send_request(fxalu_pkg::CMD_MIN, MIN_NEG, MAX_POS, 0);
		send_request(fxalu_pkg::CMD_MAX, MIN_NEG, MAX_POS, 0);
		send_request(fxalu_pkg::CMD_MAX, 32'd5, 32'd5, 0);
		send_request(fxalu_pkg::CMD_INC, MAX_POS, 32'd0, 0);
		send_request(fxalu_pkg::CMD_DEC, MIN_NEG, 32'd0, 0);
		send_request(fxalu_pkg::CMD_TOINT, 32'hFFFF_FF01, 32'd0, 0);
		send_request(fxalu_pkg::CMD_TOINT, MAX_POS, 32'd0, 0);
		send_request(fxalu_pkg::CMD_FROMINT, 32'h00FF_FFFF, 32'd0, 0);
		send_request(fxalu_pkg::CMD_FROMINT, 32'hFF80_0001, 32'd0, 0);
		send_request(4'd10, 32'd3, 32'd7, 0);
		send_request(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

		// hold off until the pipeline drains
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);

		// random: back-to-back stretch first, then random idling
		for (int i = 0; i < 1500; i++) begin
			c = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
				: 4'($urandom_range(9));
			a = pick_operand();
			b = ($urandom_range(7) == 0) ? a : pick_operand();
			if (c == fxalu_pkg::CMD_DIV && $urandom_range(9) == 0)
				b = '0;
			send_request(c, a, b, i >= 300);
		end
		start <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

`default_nettype wire
